FILE: hdl/stp_seq_pkg.sv
// ----------------------------------------------------------------------------
// stp_seq_pkg
// Shared types, codes and the half-step coil table for the two-axis
// half-step stepper sequencer.
// ----------------------------------------------------------------------------
package stp_seq_pkg;

    // Geometry of the move
    localparam int PHASES_PER_CYCLE = 8;
    localparam int PHASE_W          = $clog2(PHASES_PER_CYCLE);
    localparam int CYCLES_W         = 16;
    localparam int HOLD_W           = 24;
    localparam int COIL_W           = 4;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic REG_PHASE_HOLD = 1'b0;
    localparam logic [HOLD_W-1:0] PHASE_HOLD_RESET = 24'd1000;

    // Command codes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Axis codes
    localparam logic AXIS_PAN  = 1'b0;
    localparam logic AXIS_TILT = 1'b1;

    // One command item
    typedef struct packed {
        logic               opcode;
        logic               axis;
        logic signed [15:0] steps;
    } stp_cmd_t;

    // One result item
    typedef struct packed {
        logic [COIL_W-1:0] pan_coils;
        logic [COIL_W-1:0] tilt_coils;
        logic              pan_enable;
        logic              tilt_enable;
        logic              busy_res;
        logic              accepted;
    } stp_res_t;

    // Half-step coil pattern, forward and reverse tables
    function automatic logic [COIL_W-1:0] coil_pattern(
        input logic               rev,
        input logic [PHASE_W-1:0] ph
    );
        logic [COIL_W-1:0] pat;
        unique case (ph)
            3'd0:    pat = 4'h1;
            3'd1:    pat = 4'h3;
            3'd2:    pat = 4'h2;
            3'd3:    pat = 4'h6;
            3'd4:    pat = 4'h4;
            3'd5:    pat = 4'hC;
            3'd6:    pat = 4'h8;
            default: pat = 4'h9;
        endcase
        // reverse table is the forward table read backwards
        if (rev)
        begin
            unique case (ph)
                3'd0:    pat = 4'h9;
                3'd1:    pat = 4'h8;
                3'd2:    pat = 4'hC;
                3'd3:    pat = 4'h4;
                3'd4:    pat = 4'h6;
                3'd5:    pat = 4'h2;
                3'd6:    pat = 4'h3;
                default: pat = 4'h1;
            endcase
        end
        return pat;
    endfunction

endpackage

FILE: hdl/stp_seq_cfg.sv
// ----------------------------------------------------------------------------
// stp_seq_cfg
// APB-style register file holding the phase hold time.
// ----------------------------------------------------------------------------
module stp_seq_cfg
    import stp_seq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [HOLD_W-1:0]     phase_hold
);

    logic [HOLD_W-1:0] phase_hold_reg;
    logic              hit;

    // register index is the word address
    assign hit    = (paddr[2] == REG_PHASE_HOLD);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_hold_reg <= PHASE_HOLD_RESET;
        end
        else if (psel && penable && pwrite && hit)
        begin
            phase_hold_reg <= pwdata[HOLD_W-1:0];
        end
    end

    // read back
    always_comb
    begin
        prdata = '0;
        if (hit)
        begin
            prdata = {{(APB_DATA_W-HOLD_W){1'b0}}, phase_hold_reg};
        end
    end

    assign phase_hold = phase_hold_reg;

endmodule

FILE: hdl/stp_seq_core.sv
// ----------------------------------------------------------------------------
// stp_seq_core
// Move state and the single-pass update for one tick or start item.
// ----------------------------------------------------------------------------
module stp_seq_core
    import stp_seq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  stp_cmd_t          cmd,
    input  logic [HOLD_W-1:0] phase_hold,
    output stp_res_t          res
);

    logic [CYCLES_W-1:0] cycles_left_reg, cycles_left_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic                reverse_reg, reverse_next;
    logic                axis_reg, axis_next;
    logic [HOLD_W-1:0]   hold_count_reg, hold_count_next;
    logic                running_reg, running_next;
    logic                accepted;

    logic [HOLD_W-1:0]   hold_eff;
    logic [HOLD_W-1:0]   hold_inc;
    logic [CYCLES_W-1:0] mag;
    logic [CYCLES_W-1:0] cycles_dec;
    logic [COIL_W-1:0]   coils;

    // zero hold acts as one tick
    assign hold_eff   = (phase_hold == '0) ? HOLD_W'(1) : phase_hold;
    assign hold_inc   = hold_count_reg + HOLD_W'(1);
    assign cycles_dec = cycles_left_reg - CYCLES_W'(1);
    // -32768 maps to 32768, which still fits
    assign mag = cmd.steps[15] ? CYCLES_W'(-cmd.steps) : CYCLES_W'(cmd.steps);

    // next state
    always_comb
    begin
        cycles_left_next = cycles_left_reg;
        phase_next       = phase_reg;
        reverse_next     = reverse_reg;
        axis_next        = axis_reg;
        hold_count_next  = hold_count_reg;
        running_next     = running_reg;
        accepted         = 1'b0;
        if (cmd.opcode == OP_START)
        begin
            if (!running_reg && (cmd.steps != '0))
            begin
                cycles_left_next = mag;
                phase_next       = '0;
                hold_count_next  = '0;
                reverse_next     = cmd.steps[15];
                axis_next        = cmd.axis;
                running_next     = 1'b1;
                accepted         = 1'b1;
            end
        end
        else if (running_reg)
        begin
            hold_count_next = hold_inc;
            if (hold_inc >= hold_eff)
            begin
                hold_count_next = '0;
                phase_next      = phase_reg + PHASE_W'(1);
                // phase wraps: one full cycle done
                if (phase_reg == PHASE_W'(PHASES_PER_CYCLE - 1))
                begin
                    cycles_left_next = cycles_dec;
                    if (cycles_dec == '0)
                    begin
                        running_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycles_left_reg <= '0;
            phase_reg       <= '0;
            reverse_reg     <= 1'b0;
            axis_reg        <= AXIS_PAN;
            hold_count_reg  <= '0;
            running_reg     <= 1'b0;
        end
        else if (fire)
        begin
            cycles_left_reg <= cycles_left_next;
            phase_reg       <= phase_next;
            reverse_reg     <= reverse_next;
            axis_reg        <= axis_next;
            hold_count_reg  <= hold_count_next;
            running_reg     <= running_next;
        end
    end

    // result shows the state after the item
    assign coils = coil_pattern(reverse_next, phase_next);

    always_comb
    begin
        res             = '0;
        res.busy_res    = running_next;
        res.accepted    = accepted;
        res.pan_enable  = running_next && (axis_next == AXIS_PAN);
        res.tilt_enable = running_next && (axis_next == AXIS_TILT);
        if (res.pan_enable)
        begin
            res.pan_coils = coils;
        end
        if (res.tilt_enable)
        begin
            res.tilt_coils = coils;
        end
    end

endmodule

FILE: hdl/stepper_half_step_sequencer.sv
// ----------------------------------------------------------------------------
// stepper_half_step_sequencer
// Two-axis (pan/tilt) half-step stepper sequencer with tick and start items.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid/cmd_stall/cmd) carries one item per handshake:
//   a time tick or a start command with axis and signed cycle count.
//   res channel (res_valid/res_stall/res) returns exactly one result item
//   per command item: coil lines, enables, busy and the accepted flag,
//   showing the move state after that item.
//   The APB port holds phase_hold_ticks at byte address 0; write it only
//   while no item is in flight.
// Timing:
//   An accepted cmd item goes into the command register, then in one pass
//   through the update logic into the result register, where res_valid
//   rises. One item per cycle is sustained while res is not stalled; the
//   state update is a single increment/compare per item, closed in that
//   one pass.
// Reset clears the move state, both pipeline valids, and loads a hold of
//   1000 ticks. While res is stalled the result register holds; the command
//   register still takes one more item, then cmd_stall rises.
// ----------------------------------------------------------------------------
module stepper_half_step_sequencer
    import stp_seq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  stp_cmd_t              cmd,
    output logic                  res_valid,
    input  logic                  res_stall,
    output stp_res_t              res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic              cmd_valid_reg;
    stp_cmd_t          cmd_reg;
    logic              res_valid_reg;
    stp_res_t          res_reg;
    logic              advance;
    logic              take;
    logic [HOLD_W-1:0] phase_hold;
    stp_res_t          res_next;

    stp_seq_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .phase_hold (phase_hold)
    );

    stp_seq_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (advance),
        .cmd        (cmd_reg),
        .phase_hold (phase_hold),
        .res        (res_next)
    );

    // pipeline handshakes
    assign advance   = cmd_valid_reg && (!res_valid_reg || !res_stall);
    assign cmd_stall = cmd_valid_reg && !advance;
    assign take      = cmd_valid && !cmd_stall;

    // command register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            cmd_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            cmd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= cmd;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // checks
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.accepted |-> res.busy_res)
        else $error("accepted start without busy");

    a_busy_enable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.busy_res == (res.pan_enable || res.tilt_enable)))
        else $error("busy and enables disagree");

    a_one_axis: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res.pan_enable && res.tilt_enable))
        else $error("both axes enabled");

    a_idle_coils: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.busy_res |-> (res.pan_coils == '0) && (res.tilt_coils == '0))
        else $error("coils driven while idle");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> res_valid && res_stall && cmd_valid_reg)
        else $error("command stalled with room downstream");

endmodule
